// ===== design/trie_insert_search_prefix_unit_defines.svh =====
// Assertion macros shared by the trie unit modules.
`ifndef TRIE_INSERT_SEARCH_PREFIX_UNIT_DEFINES_SVH
`define TRIE_INSERT_SEARCH_PREFIX_UNIT_DEFINES_SVH

// Same-cycle implication.
`define TISP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TISP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tisp_pkg.sv =====
package tisp_pkg;

  localparam int LETTER_W    = 5;
  localparam int KIND_W      = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_PREFIX = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               op;
    logic [LETTER_W-1:0] letter;
    logic                letter_ok;
    logic                no_letter;
    logic                first;
    logic                last;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } state_t;

endpackage

// ===== design/tisp_front.sv =====
module tisp_front #(
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                         start,
  input  logic [tisp_pkg::KIND_W-1:0]  kind,
  input  logic [tisp_pkg::LETTER_W-1:0] letter,
  input  logic                         no_letter,
  input  logic                         first_letter,
  input  logic                         last_letter,
  input  tisp_pkg::back_status_t       status,
  input  logic                         q_full,
  output logic                         busy,
  output logic                         push,
  output tisp_pkg::item_t              item
);

  tisp_pkg::kind_t op;

  // kind three is treated as a prefix search
  always_comb begin
    unique case (kind)
      tisp_pkg::KIND_INSERT: op = tisp_pkg::KIND_INSERT;
      tisp_pkg::KIND_SEARCH: op = tisp_pkg::KIND_SEARCH;
      default:               op = tisp_pkg::KIND_PREFIX;
    endcase
  end

  always_comb begin
    item.op        = op;
    item.letter    = letter;
    item.letter_ok = 32'(letter) < 32'(ALPHABET_SIZE);
    item.no_letter = no_letter;
    item.first     = first_letter;
    item.last      = last_letter;
  end

  assign busy = status.clearing || q_full;
  assign push = start && !busy;

endmodule

// ===== design/tisp_queue.sv =====
`include "trie_insert_search_prefix_unit_defines.svh"

module tisp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tisp_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output tisp_pkg::item_t pop_item,
  output logic            empty
);

  tisp_pkg::item_t entries [tisp_pkg::QUEUE_DEPTH];
  logic [tisp_pkg::QPTR_W-1:0] wr_ptr;
  logic [tisp_pkg::QPTR_W-1:0] rd_ptr;
  logic [tisp_pkg::QPTR_W:0]   count;

  assign full     = count == (tisp_pkg::QPTR_W + 1)'(tisp_pkg::QUEUE_DEPTH);
  assign empty    = count == '0;
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `TISP_ASSERT_NOW(a_no_push_full, clk, rst, push, !full, "queue push while full")
  `TISP_ASSERT_NOW(a_no_pop_empty, clk, rst, pop, !empty, "queue pop while empty")

endmodule

// ===== design/tisp_back.sv =====
`include "trie_insert_search_prefix_unit_defines.svh"

module tisp_back #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                        clk,
  input  logic                        rst,
  input  tisp_pkg::item_t             q_item,
  input  logic                        q_empty,
  output logic                        q_pop,
  output tisp_pkg::back_status_t      status,
  output logic                        done,
  output logic [tisp_pkg::KIND_W-1:0] op_echo,
  output logic                        found,
  output logic                        pool_full
);

  localparam int NW     = (NODE_COUNT > 2) ? $clog2(NODE_COUNT) : 1;
  localparam int SLOTS  = (ALPHABET_SIZE < 32) ? ALPHABET_SIZE : 32;
  localparam int ROW_W  = SLOTS * NW;
  localparam int FREE_W = NW + 1;

  tisp_pkg::state_t state, state_next;
  tisp_pkg::item_t  item;

  logic [NW-1:0]     clr_addr;
  logic [NW-1:0]     cursor, cursor_next;
  logic              path_missing, path_missing_next;
  logic              overflowed, overflowed_next;
  logic [FREE_W-1:0] next_free, next_free_next;

  // one row per node: the child links of all letters
  logic [ROW_W-1:0] node_mem [NODE_COUNT];
  logic [ROW_W-1:0] node_rdata, node_wdata;
  logic [NW-1:0]    node_raddr, node_waddr;
  logic             node_we;

  logic          end_mem [NODE_COUNT];
  logic          end_rdata, end_wdata;
  logic [NW-1:0] end_raddr, end_waddr;
  logic          end_we;

  logic [NW-1:0]    base_cur, child;
  logic             base_miss, base_ovf, take_step, alloc;
  logic [ROW_W-1:0] linked_row;
  logic             walk_ok, found_next, mark_end;

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    node_rdata <= node_mem[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (end_we) begin
      end_mem[end_waddr] <= end_wdata;
    end
    end_rdata <= end_mem[end_raddr];
  end

  // child lookup and link insertion in the row just read
  always_comb begin
    child      = '0;
    linked_row = node_rdata;
    for (int i = 0; i < SLOTS; i++) begin
      if (item.letter == 5'(i)) begin
        child                  = node_rdata[i*NW +: NW];
        linked_row[i*NW +: NW] = next_free[NW-1:0];
      end
    end
  end

  // one letter step of the walk
  always_comb begin
    base_cur          = item.first ? '0 : cursor;
    base_miss         = item.first ? 1'b0 : path_missing;
    base_ovf          = item.first ? 1'b0 : overflowed;
    cursor_next       = base_cur;
    path_missing_next = base_miss;
    overflowed_next   = base_ovf;
    next_free_next    = next_free;
    alloc             = 1'b0;
    take_step         = !item.no_letter && !base_miss && !base_ovf;
    if (take_step) begin
      if (!item.letter_ok) begin
        path_missing_next = 1'b1;
      end else if (child != '0) begin
        cursor_next = child;
      end else if (item.op == tisp_pkg::KIND_INSERT) begin
        if (next_free >= FREE_W'(NODE_COUNT)) begin
          overflowed_next = 1'b1;
        end else begin
          alloc          = 1'b1;
          cursor_next    = next_free[NW-1:0];
          next_free_next = FREE_W'(next_free + 1'b1);
        end
      end else begin
        path_missing_next = 1'b1;
      end
    end
  end

  always_comb begin
    walk_ok = !path_missing && !overflowed;
    case (item.op)
      tisp_pkg::KIND_SEARCH: found_next = walk_ok && end_rdata;
      default:               found_next = walk_ok;
    endcase
    mark_end = (item.op == tisp_pkg::KIND_INSERT) && walk_ok;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tisp_pkg::ST_CLEAR: begin
        if (clr_addr == NW'(NODE_COUNT - 1)) begin
          state_next = tisp_pkg::ST_IDLE;
        end
      end
      tisp_pkg::ST_IDLE: begin
        if (!q_empty) begin
          state_next = tisp_pkg::ST_EXEC;
        end
      end
      tisp_pkg::ST_EXEC: begin
        state_next = item.last ? tisp_pkg::ST_FIN : tisp_pkg::ST_IDLE;
      end
      tisp_pkg::ST_FIN: state_next = tisp_pkg::ST_IDLE;
      default:          state_next = tisp_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    q_pop           = 1'b0;
    status.clearing = 1'b0;
    node_raddr      = q_item.first ? '0 : cursor;
    node_we         = 1'b0;
    node_waddr      = base_cur;
    node_wdata      = linked_row;
    end_raddr       = cursor_next;
    end_we          = 1'b0;
    end_waddr       = cursor;
    end_wdata       = 1'b1;
    unique case (state)
      tisp_pkg::ST_CLEAR: begin
        status.clearing = 1'b1;
        node_we         = 1'b1;
        node_waddr      = clr_addr;
        node_wdata      = '0;
        end_we          = 1'b1;
        end_waddr       = clr_addr;
        end_wdata       = 1'b0;
      end
      tisp_pkg::ST_IDLE: q_pop = !q_empty;
      tisp_pkg::ST_EXEC: node_we = alloc;
      tisp_pkg::ST_FIN:  end_we = mark_end;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tisp_pkg::ST_CLEAR;
      clr_addr     <= '0;
      cursor       <= '0;
      path_missing <= 1'b0;
      overflowed   <= 1'b0;
      next_free    <= FREE_W'(1);
      done         <= 1'b0;
    end else begin
      state <= state_next;
      done  <= state == tisp_pkg::ST_FIN;
      if (state == tisp_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == tisp_pkg::ST_EXEC) begin
        cursor       <= cursor_next;
        path_missing <= path_missing_next;
        overflowed   <= overflowed_next;
        next_free    <= next_free_next;
      end else if (state == tisp_pkg::ST_FIN) begin
        cursor       <= '0;
        path_missing <= 1'b0;
        overflowed   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      item <= q_item;
    end
    if (state == tisp_pkg::ST_FIN) begin
      op_echo   <= item.op;
      found     <= found_next;
      pool_full <= (item.op == tisp_pkg::KIND_INSERT) && overflowed;
    end
  end

  `TISP_ASSERT_NEXT(a_done_single, clk, rst, done, !done, "result strobe held too long")
  `TISP_ASSERT_NOW(a_no_pop_clear, clk, rst, state == tisp_pkg::ST_CLEAR, !q_pop, "pop in clear")
  `TISP_ASSERT_NOW(a_free_bound, clk, rst, 1'b1, next_free <= FREE_W'(NODE_COUNT), "pool bound")
  `TISP_ASSERT_NOW(a_result_excl, clk, rst, done, !(found && pool_full), "found with full pool")

endmodule

// ===== design/trie_insert_search_prefix_unit.sv =====
// Result path: a word's last beat goes through the queue, ST_IDLE (pop) and ST_EXEC,
// then ST_FIN, after which done is registered; earlier queued beats are served first.
// Back end: one beat at a time, via ST_IDLE (node-row read) and ST_EXEC (link write);
// a last beat adds ST_FIN (end-mark access); a 4-beat queue decouples the command port.
// Reset: synchronous; afterwards busy stays high while a clearing pass zeroes all NODE_COUNT
// node rows and end marks, one node row and end mark per cycle. Results cannot be stalled.
module trie_insert_search_prefix_unit #(
  parameter int NODE_COUNT    = 1024,
  parameter int ALPHABET_SIZE = 26
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [tisp_pkg::KIND_W-1:0]   kind,
  input  logic [tisp_pkg::LETTER_W-1:0] letter,
  input  logic                          no_letter,
  input  logic                          first_letter,
  input  logic                          last_letter,
  output logic                          done,
  output logic [tisp_pkg::KIND_W-1:0]   op_echo,
  output logic                          found,
  output logic                          pool_full
);

  tisp_pkg::back_status_t status;
  tisp_pkg::item_t        push_item, pop_item;
  logic                   push, q_full, q_pop, q_empty;

  tisp_front #(
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_front (
    .start       (start),
    .kind        (kind),
    .letter      (letter),
    .no_letter   (no_letter),
    .first_letter(first_letter),
    .last_letter (last_letter),
    .status      (status),
    .q_full      (q_full),
    .busy        (busy),
    .push        (push),
    .item        (push_item)
  );

  tisp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .full     (q_full),
    .pop      (q_pop),
    .pop_item (pop_item),
    .empty    (q_empty)
  );

  tisp_back #(
    .NODE_COUNT   (NODE_COUNT),
    .ALPHABET_SIZE(ALPHABET_SIZE)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_item   (pop_item),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .status   (status),
    .done     (done),
    .op_echo  (op_echo),
    .found    (found),
    .pool_full(pool_full)
  );

endmodule

// ===== sim/trie_insert_search_prefix_unit_tb.sv =====
`timescale 1ns / 1ps

module trie_insert_search_prefix_unit_tb;

  localparam int NODE_COUNT   = 1024;
  localparam int ALPHABET     = 26;
  localparam int WORD_MAX     = 24;
  localparam int DRAIN_CYCLES = 40;
  // unused code, block treats it as prefix
  localparam logic [tisp_pkg::KIND_W-1:0] KIND_ODD = 2'd3;

  typedef struct packed {
    logic [5:0]                                  len;
    logic [WORD_MAX-1:0][tisp_pkg::LETTER_W-1:0] ch;
  } word_t;

  typedef struct {
    tisp_pkg::kind_t op;
    bit              found;
    bit              full;
  } trie_result_t;

  logic                          clk;
  logic                          rst          = 1'b1;
  logic                          start        = 1'b0;
  logic                          busy;
  logic [tisp_pkg::KIND_W-1:0]   kind         = '0;
  logic [tisp_pkg::LETTER_W-1:0] letter       = '0;
  logic                          no_letter    = 1'b0;
  logic                          first_letter = 1'b0;
  logic                          last_letter  = 1'b0;
  logic                          done;
  logic [tisp_pkg::KIND_W-1:0]   op_echo;
  logic                          found;
  logic                          pool_full;

  trie_insert_search_prefix_unit #(
    .NODE_COUNT   (NODE_COUNT),
    .ALPHABET_SIZE(ALPHABET)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .letter      (letter),
    .no_letter   (no_letter),
    .first_letter(first_letter),
    .last_letter (last_letter),
    .done        (done),
    .op_echo     (op_echo),
    .found       (found),
    .pool_full   (pool_full)
  );

  // trie shadow
  bit [9:0]    child_link [NODE_COUNT*ALPHABET];
  bit          word_end   [NODE_COUNT];
  int unsigned free_node  = 1;
  int unsigned walk_node  = 0;
  bit          walk_lost  = 1'b0;
  bit          walk_overflow = 1'b0;

  trie_result_t pending_results[$];
  word_t        dict[$];

  bit          idle_on     = 1'b1;
  int unsigned err_count   = 0;
  int unsigned beats_sent  = 0;
  int unsigned results_seen = 0;
  int unsigned found_count = 0;
  int unsigned full_count  = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("TIMEOUT at %0t", $time);
    $display("trie_insert_search_prefix_unit test failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    err_count++;
  endtask

  function automatic void walk_home();
    walk_node     = 0;
    walk_lost     = 1'b0;
    walk_overflow = 1'b0;
  endfunction

  // Advance the shadow trie by one accepted beat; queue a result on the word's last beat.
  function automatic void trie_walk_beat(input logic [tisp_pkg::KIND_W-1:0] k,
                                         input logic [tisp_pkg::LETTER_W-1:0] l,
                                         input bit nl, input bit f, input bit la);
    tisp_pkg::kind_t op;
    int unsigned     slot;
    bit [9:0]        nxt;
    bit              ok;
    trie_result_t    r;
    op = (k == KIND_ODD) ? tisp_pkg::KIND_PREFIX : tisp_pkg::kind_t'(k);
    if (f) walk_home();
    if (!nl && !walk_lost && !walk_overflow) begin
      if (l >= ALPHABET) begin
        walk_lost = 1'b1;
      end else begin
        slot = walk_node * ALPHABET + l;
        nxt  = child_link[slot];
        if (nxt == 0) begin
          if (op == tisp_pkg::KIND_INSERT) begin
            if (free_node >= NODE_COUNT) begin
              walk_overflow = 1'b1;
            end else begin
              child_link[slot] = free_node[9:0];
              walk_node        = free_node;
              free_node++;
            end
          end else begin
            walk_lost = 1'b1;
          end
        end else begin
          walk_node = 32'(nxt);
        end
      end
    end
    if (la) begin
      ok      = !walk_lost && !walk_overflow;
      r.op    = op;
      r.found = 1'b0;
      r.full  = 1'b0;
      case (op)
        tisp_pkg::KIND_INSERT: begin
          if (ok) begin
            word_end[walk_node] = 1'b1;
            r.found = 1'b1;
          end
          r.full = walk_overflow;
        end
        tisp_pkg::KIND_SEARCH: r.found = ok && word_end[walk_node];
        default:               r.found = ok;
      endcase
      pending_results.push_back(r);
      walk_home();
    end
  endfunction

  // start stays high across back-to-back beats; it only drops inside an idle burst.
  task automatic send_beat(input logic [tisp_pkg::KIND_W-1:0] k,
                           input logic [tisp_pkg::LETTER_W-1:0] l,
                           input bit nl, input bit f, input bit la);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    start        <= 1'b1;
    kind         <= k;
    letter       <= l;
    no_letter    <= nl;
    first_letter <= f;
    last_letter  <= la;
    do @(posedge clk); while (busy !== 1'b0);
    trie_walk_beat(k, l, nl, f, la);
    beats_sent++;
  endtask

  task automatic send_word(input logic [tisp_pkg::KIND_W-1:0] k, input word_t w);
    if (w.len == 0) begin
      send_beat(k, tisp_pkg::LETTER_W'($urandom_range(0, 31)), 1'b1, 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < w.len; i++)
        send_beat(k, w.ch[i], 1'b0, i == 0, i == w.len - 1);
    end
  endtask

  function automatic word_t word_of(input string s);
    word_t w;
    w     = '0;
    w.len = 6'(s.len());
    for (int i = 0; i < s.len(); i++) w.ch[i] = tisp_pkg::LETTER_W'(s[i] - "a");
    return w;
  endfunction

  function automatic word_t random_word(input int min_len, input int max_len,
                                        input int top_letter);
    word_t w;
    w     = '0;
    w.len = 6'($urandom_range(min_len, max_len));
    for (int i = 0; i < w.len; i++)
      w.ch[i] = tisp_pkg::LETTER_W'($urandom_range(0, top_letter));
    return w;
  endfunction

  // Mostly a narrow alphabet so paths collide; now and then a letter past z.
  function automatic word_t fresh_word();
    word_t       w;
    int unsigned span;
    span = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) w = random_word(0, 0, 0);
    else if (span < 70)             w = random_word(1, 6, 3);
    else                            w = random_word(1, 6, ALPHABET - 1);
    if (w.len != 0 && $urandom_range(0, 19) == 0)
      w.ch[$urandom_range(0, w.len - 1)] = tisp_pkg::LETTER_W'($urandom_range(ALPHABET, 31));
    return w;
  endfunction

  function automatic word_t known_word_variant();
    word_t w;
    w = dict[$urandom_range(0, dict.size() - 1)];
    if (w.len > 1 && $urandom_range(0, 2) == 0) w.len = 6'($urandom_range(1, w.len));
    if (w.len > 0 && $urandom_range(0, 4) == 0)
      w.ch[$urandom_range(0, w.len - 1)] = tisp_pkg::LETTER_W'($urandom_range(0, ALPHABET - 1));
    return w;
  endfunction

  function automatic void remember_word(input word_t w);
    dict.push_back(w);
    if (dict.size() > 256) void'(dict.pop_front());
  endfunction

  always @(posedge clk) begin : check_results
    trie_result_t want;
    if (!rst && done !== 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result strobe with no word pending");
      end else begin
        want = pending_results.pop_front();
        if (op_echo !== want.op)
          report_mismatch($sformatf("op_echo %0d, want %0d", op_echo, want.op));
        if (found !== want.found)
          report_mismatch($sformatf("found %b, want %b (op %0d)", found, want.found, want.op));
        if (pool_full !== want.full)
          report_mismatch($sformatf("pool_full %b, want %b", pool_full, want.full));
        results_seen++;
        if (want.found) found_count++;
        if (want.full) full_count++;
      end
    end
  end

  task automatic test_empty_word();
    send_word(tisp_pkg::KIND_SEARCH, word_of(""));   // root not marked yet
    send_word(tisp_pkg::KIND_PREFIX, word_of(""));
    send_word(tisp_pkg::KIND_INSERT, word_of(""));
    send_word(tisp_pkg::KIND_SEARCH, word_of(""));
  endtask

  task automatic test_word_paths();
    word_t w;
    send_word(tisp_pkg::KIND_INSERT, word_of("cab"));
    send_word(tisp_pkg::KIND_SEARCH, word_of("ca"));
    send_word(tisp_pkg::KIND_PREFIX, word_of("ca"));
    send_word(tisp_pkg::KIND_SEARCH, word_of("cab"));
    send_word(tisp_pkg::KIND_INSERT, word_of("a"));
    send_word(tisp_pkg::KIND_INSERT, word_of("z"));
    send_word(KIND_ODD, word_of("ca"));
    w       = word_of("b");
    w.ch[0] = tisp_pkg::LETTER_W'(31);
    send_word(tisp_pkg::KIND_INSERT, w);
    w.ch[0] = tisp_pkg::LETTER_W'(ALPHABET);
    send_word(tisp_pkg::KIND_PREFIX, w);
  endtask

  task automatic test_irregular_beats();
    // continuation without a first mark starts at the root after a finished word
    send_beat(tisp_pkg::KIND_SEARCH, tisp_pkg::LETTER_W'("c" - "a"), 1'b0, 1'b0, 1'b0);
    send_beat(tisp_pkg::KIND_SEARCH, tisp_pkg::LETTER_W'("a" - "a"), 1'b0, 1'b0, 1'b1);
    // kind switches mid-word; the search beat misses
    send_beat(tisp_pkg::KIND_INSERT, tisp_pkg::LETTER_W'("z" - "a"), 1'b0, 1'b1, 1'b0);
    send_beat(tisp_pkg::KIND_SEARCH, tisp_pkg::LETTER_W'("y" - "a"), 1'b0, 1'b0, 1'b1);
    // letterless last beat ends an insert in place
    send_beat(tisp_pkg::KIND_INSERT, tisp_pkg::LETTER_W'("q" - "a"), 1'b0, 1'b1, 1'b0);
    send_beat(tisp_pkg::KIND_INSERT, tisp_pkg::LETTER_W'(31), 1'b1, 1'b0, 1'b1);
  endtask

  task automatic test_random_words(input int unsigned n, input bit allow_idle);
    int unsigned first_beat;
    int unsigned pick;
    int unsigned iter;
    logic [tisp_pkg::KIND_W-1:0] k;
    word_t w;
    first_beat = beats_sent;
    iter       = 0;
    idle_on    = allow_idle;
    while (beats_sent - first_beat < n) begin
      if (allow_idle && iter % 24 == 0) idle_on = ($urandom_range(0, 2) != 0);
      iter++;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        send_beat(tisp_pkg::KIND_W'($urandom_range(0, 3)),
                  tisp_pkg::LETTER_W'($urandom_range(0, 31)),
                  $urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 35)      k = tisp_pkg::KIND_INSERT;
        else if (pick < 65) k = tisp_pkg::KIND_SEARCH;
        else if (pick < 95) k = tisp_pkg::KIND_PREFIX;
        else                k = KIND_ODD;
        if (k != tisp_pkg::KIND_INSERT && dict.size() != 0 && $urandom_range(0, 9) < 6)
          w = known_word_variant();
        else
          w = fresh_word();
        send_word(k, w);
        if (k == tisp_pkg::KIND_INSERT) remember_word(w);
      end
    end
  endtask

  task automatic test_pool_exhaustion();
    word_t w;
    idle_on = 1'b1;
    while (free_node < NODE_COUNT) begin
      w = random_word(16, WORD_MAX, ALPHABET - 1);
      send_word(tisp_pkg::KIND_INSERT, w);
      remember_word(w);
    end
    repeat (6) begin
      send_word(tisp_pkg::KIND_INSERT, random_word(2, 8, ALPHABET - 1));
      send_word(tisp_pkg::KIND_SEARCH, known_word_variant());
      send_word(tisp_pkg::KIND_PREFIX, known_word_variant());
    end
    // an old word inserted again with the pool exhausted
    send_word(tisp_pkg::KIND_INSERT, dict[0]);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_empty_word();
    test_word_paths();
    test_irregular_beats();
    test_random_words(900, 1'b1);
    test_pool_exhaustion();
    test_random_words(150, 1'b0);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d beats; checked %0d word results, %0d found, %0d hit the full pool.",
             beats_sent, results_seen, found_count, full_count);
    $display("Node pool used: %0d of %0d nodes.", free_node, NODE_COUNT);
    if (err_count == 0) begin
      $display("trie_insert_search_prefix_unit test passed");
    end else begin
      $display("%0d mismatches", err_count);
      $display("trie_insert_search_prefix_unit test failed");
    end
    $finish;
  end

endmodule
